FILE: sv/pst_pkg.sv
package pst_pkg;
  localparam int LEAVES = 1024;
  localparam int LVW = $clog2(LEAVES);
  localparam int AW = LVW + 1;
  localparam int IW = 11;
  localparam int VW = 17;
  localparam logic [VW-1:0] ONE_FX = 17'h10000;
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_SCALE = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  function automatic logic [VW-1:0] fx_mul(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [2*VW-1:0] p;
    begin
      p = a * b;
      fx_mul = p[VW+15:16];
    end
  endfunction
endpackage

FILE: sv/pst_node_ram.sv
module pst_node_ram
  import pst_pkg::*;
(
  input  logic          clk,
  input  mem_req_t      req,
  output logic [VW-1:0] rdata
);
  logic [VW-1:0] mem [0:2*LEAVES-1];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end
endmodule

FILE: sv/product_segment_tree.sv
// Product segment tree, 1024 leaves in Q1.16 (65536 = 1.0).
// in_* beat: tdata = {operand_value, right_index, left_index, func}, high bits first.
// func 0 loads a leaf, 1 scales a leaf by (1 - c), 2 returns the range product on out_*.
// out_* beat: tdata = {range_error, product}. Loads, scales and func 3 give no beat.
// cfg_we/cfg_wdata set leaf_count (reset 1024); write only while idle.
// All node state lives in one RAM with one write and one read port and registered
// read data. After reset a clearing pass writes 1.0 to all 2048 entries with
// in_tready low. A load or scale with an in-range index holds in_tready low after
// its beat while it reads and writes the leaf, then does two reads and a write per
// ancestor level. A query walks up the tree a level at a time, reading at most one
// left and one right node per level; a bad range gives its result the next cycle.
// One item is worked at a time.
// A finished result waits in the output register; while out_tready is low the
// block holds and does not take the next beat.
module product_segment_tree
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // func, left_index, right_index, operand_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // product, range_error
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LRD = 4'd2, S_LWR = 4'd3,
    S_URDA = 4'd4, S_URDB = 4'd5, S_UWR = 4'd6, S_QLP = 4'd7, S_QLW = 4'd8,
    S_QRW = 4'd9, S_QFIN = 4'd10, S_OUT = 4'd11, S_UWAIT = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [AW:0]   b_r, b_nxt;
  logic [VW-1:0] accl_r, accl_nxt, accr_r, accr_nxt, t_r, t_nxt, opv_r, opv_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [IW-1:0] cnt_r;
  logic [VW-1:0] prod_r, prod_nxt;
  logic          err_r, err_nxt;
  mem_req_t      req;
  logic [VW-1:0] rdata;

  logic [1:0]    f;
  logic [IW-1:0] lo, hi, n;
  logic [VW-1:0] opv;
  assign f  = in_tdata[1:0];
  assign lo = in_tdata[12:2];
  assign hi = in_tdata[23:13];
  assign opv = (in_tdata[40:24] > ONE_FX) ? ONE_FX : in_tdata[40:24];
  assign n = (cnt_r > IW'(LEAVES)) ? IW'(LEAVES) : cnt_r;

  pst_node_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {6'd0, err_r, prod_r};

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; accl_nxt = accl_r; accr_nxt = accr_r;
    t_nxt = t_r; opv_nxt = opv_r; func_nxt = func_r; prod_nxt = prod_r; err_nxt = err_r;
    req = '0;
    unique case (st_r)
      S_CLR: begin
        req.we = 1'b1; req.waddr = a_r; req.wdata = ONE_FX;
        a_nxt = a_r + 1'b1;
        if (&a_r) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt = f; opv_nxt = opv;
          if (f == FUNC_LOAD || f == FUNC_SCALE) begin
            if (lo != '0 && lo <= n) begin
              a_nxt = AW'(LEAVES) + AW'(lo) - 1'b1;
              req.re = 1'b1; req.raddr = AW'(LEAVES) + AW'(lo) - 1'b1;
              st_nxt = S_LRD;
            end
          end else if (f == FUNC_QUERY) begin
            if (lo == '0 || hi < lo || hi > n) begin
              prod_nxt = '0; err_nxt = 1'b1; st_nxt = S_OUT;
            end else begin
              a_nxt = AW'(LEAVES) + AW'(lo) - 1'b1;
              b_nxt = (AW+1)'(LEAVES) + (AW+1)'(hi);
              accl_nxt = ONE_FX; accr_nxt = ONE_FX; err_nxt = 1'b0;
              st_nxt = S_QLP;
            end
          end
        end
      end
      S_LRD: st_nxt = S_LWR;
      S_LWR: begin
        req.we = 1'b1; req.waddr = a_r;
        req.wdata = (func_r == FUNC_LOAD) ? opv_r : fx_mul(rdata, ONE_FX - opv_r);
        st_nxt = S_UWAIT;
      end
      S_UWAIT: begin
        // a_r is the child just written; read its pair
        if (a_r[AW-1:1] == '0) st_nxt = S_IDLE;
        else begin
          req.re = 1'b1; req.raddr = {a_r[AW-1:1], 1'b0};
          st_nxt = S_URDA;
        end
      end
      S_URDA: begin
        t_nxt = rdata;
        req.re = 1'b1; req.raddr = {a_r[AW-1:1], 1'b1};
        st_nxt = S_URDB;
      end
      S_URDB: st_nxt = S_UWR;
      S_UWR: begin
        req.we = 1'b1; req.waddr = a_r >> 1; req.wdata = fx_mul(t_r, rdata);
        a_nxt = a_r >> 1;
        st_nxt = S_UWAIT;
      end
      S_QLP: begin
        if (a_r >= b_r) st_nxt = S_QFIN;
        else if (a_r[0]) begin
          req.re = 1'b1; req.raddr = a_r; st_nxt = S_QLW;
        end else if (b_r[0]) begin
          req.re = 1'b1; req.raddr = AW'(b_r - 1'b1); st_nxt = S_QRW;
        end else begin
          a_nxt = a_r >> 1; b_nxt = b_r >> 1;
        end
      end
      S_QLW: begin
        accl_nxt = fx_mul(accl_r, rdata);
        a_nxt = a_r + 1'b1;
        if (b_r[0] && (a_r + 1'b1) < b_r) begin
          req.re = 1'b1; req.raddr = AW'(b_r - 1'b1); st_nxt = S_QRW;
        end else begin
          a_nxt = AW'(({1'b0, a_r} + 1'b1) >> 1); b_nxt = b_r >> 1; st_nxt = S_QLP;
        end
      end
      S_QRW: begin
        accr_nxt = fx_mul(rdata, accr_r);
        a_nxt = a_r >> 1; b_nxt = (b_r - 1'b1) >> 1;
        st_nxt = S_QLP;
      end
      S_QFIN: begin prod_nxt = fx_mul(accl_r, accr_r); st_nxt = S_OUT; end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; a_r <= '0; cnt_r <= IW'(LEAVES);
    end else begin
      st_r <= st_nxt; a_r <= a_nxt;
      if (cfg_we) cnt_r <= cfg_wdata;
    end
    b_r <= b_nxt; accl_r <= accl_nxt; accr_r <= accr_nxt; t_r <= t_nxt;
    opv_r <= opv_nxt; func_r <= func_nxt; prod_r <= prod_nxt; err_r <= err_nxt;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err_r |-> prod_r == '0) else $error("error beat with nonzero product");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(prod_r)) else $error("result lost");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
endmodule

FILE: dv/product_segment_tree_checker.sv
module product_segment_tree_checker
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          range_error;
    logic [VW-1:0] product;
  } range_result_t;

  logic [VW-1:0] tree_node [2*LEAVES];
  logic [10:0]   leaf_limit;
  range_result_t expected_products [$];

  assign pending_count = expected_products.size();

  function automatic logic [VW-1:0] qmul(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [2*VW-1:0] p;
    p = {{VW{1'b0}}, a} * {{VW{1'b0}}, b};
    return p[VW+15:16];
  endfunction

  task automatic apply_beat(logic [47:0] beat);
    logic [1:0]    op;
    int            lo, hi, n, pos, a, b;
    logic [VW-1:0] val, accl, accr;
    range_result_t res;
    op = beat[1:0];
    lo = beat[12:2];
    hi = beat[23:13];
    val = (beat[40:24] > ONE_FX) ? ONE_FX : beat[40:24];
    n = (leaf_limit > LEAVES) ? LEAVES : leaf_limit;
    if (op == FUNC_LOAD || op == FUNC_SCALE) begin
      if (lo == 0 || lo > n) return;
      pos = LEAVES + lo - 1;
      if (op == FUNC_LOAD) tree_node[pos] = val;
      else tree_node[pos] = qmul(tree_node[pos], ONE_FX - val);
      // refresh every ancestor
      for (int k = pos >> 1; k >= 1; k = k >> 1)
        tree_node[k] = qmul(tree_node[2*k], tree_node[2*k+1]);
    end else if (op == FUNC_QUERY) begin
      if (lo == 0 || hi < lo || hi > n) begin
        res.product = '0;
        res.range_error = 1'b1;
      end else begin
        accl = ONE_FX;
        accr = ONE_FX;
        a = LEAVES + lo - 1;
        b = LEAVES + hi;
        while (a < b) begin
          if (a & 1) begin
            accl = qmul(accl, tree_node[a]);
            a++;
          end
          if (b & 1) begin
            b--;
            accr = qmul(tree_node[b], accr);
          end
          a = a >> 1;
          b = b >> 1;
        end
        res.product = qmul(accl, accr);
        res.range_error = 1'b0;
      end
      expected_products.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    range_result_t exp_r;
    if (!rst_n) begin
      foreach (tree_node[k]) tree_node[k] = ONE_FX;
      leaf_limit = 11'(LEAVES);
      expected_products.delete();
    end else begin
      if (cfg_we) leaf_limit = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (expected_products.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_products.pop_front();
          if (out_tdata[VW-1:0] !== exp_r.product) begin
            $error("product: expected %0d, got %0d", exp_r.product, out_tdata[VW-1:0]);
            fail_count++;
          end
          if (out_tdata[VW] !== exp_r.range_error) begin
            $error("range_error: expected %0d, got %0d", exp_r.range_error, out_tdata[VW]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) apply_beat(in_tdata);
    end
  end
endmodule

FILE: dv/testbench.sv
module testbench;
  import pst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  int          fail_count, pending_count;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          quiet_cycles = 0;
  logic [10:0] cur_count = 11'd1024;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  product_segment_tree dut (.*);

  product_segment_tree_checker checker_i (.*);

  always @(negedge clk) begin
    if (recv_idle_pct != 0 || out_tready !== 1'b1)
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // leaves in_tvalid high after the beat; the next call replaces the beat or drops it, or the caller drops it
  task automatic send_item(logic [1:0] op, logic [10:0] lo, logic [10:0] hi, logic [16:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {7'b0, val, hi, lo, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_leaf_count(logic [10:0] cnt);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_wdata <= cnt;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_count = cnt;
  endtask

  // mostly valid indices, sometimes out of range
  function automatic logic [10:0] pick_index();
    int n;
    n = (cur_count == 0) ? 1 : ((cur_count > LEAVES) ? LEAVES : cur_count);
    if ($urandom_range(9) == 0) return 11'($urandom);
    return 11'($urandom_range(n, 1));
  endfunction

  task automatic random_burst(int items);
    logic [10:0] lo, hi;
    logic [16:0] val;
    int          r;
    for (int i = 0; i < items; i++) begin
      lo = pick_index();
      hi = pick_index();
      if ($urandom_range(3) != 0 && hi < lo) {lo, hi} = {hi, lo};
      r = $urandom_range(99);
      // values near 1.0 keep products from collapsing to zero
      if (r < 50) val = 17'(65536 - $urandom_range(2000));
      else if (r < 90) val = 17'($urandom_range(65536));
      else val = 17'($urandom);
      r = $urandom_range(99);
      if (r < 35) send_item(FUNC_LOAD, lo, hi, val);
      else if (r < 50) send_item(FUNC_SCALE, lo, hi, 17'($urandom_range(3000)));
      else if (r < 97) send_item(FUNC_QUERY, lo, hi, val);
      else send_item(2'd3, lo, hi, val);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // directed part
    send_item(FUNC_QUERY, 11'd1, 11'd1024, 17'd0);
    send_item(FUNC_LOAD, 11'd1, 11'd0, 17'h1FFFF);
    send_item(FUNC_LOAD, 11'd1024, 11'h7FF, 17'd32768);
    send_item(FUNC_SCALE, 11'd1024, 11'd0, 17'd16384);
    send_item(FUNC_SCALE, 11'd2, 11'd0, 17'd65536);
    send_item(FUNC_SCALE, 11'd3, 11'd0, 17'h1FFFF);
    send_item(FUNC_LOAD, 11'd0, 11'd0, 17'd5);
    send_item(FUNC_LOAD, 11'd1025, 11'd0, 17'd5);
    send_item(FUNC_LOAD, 11'h7FF, 11'd0, 17'd5);
    send_item(2'd3, 11'd1, 11'd1, 17'd0);
    send_item(FUNC_QUERY, 11'd1, 11'd1024, 17'd0);
    send_item(FUNC_QUERY, 11'd4, 11'd1024, 17'd0);
    send_item(FUNC_QUERY, 11'd0, 11'd5, 17'd0);
    send_item(FUNC_QUERY, 11'd6, 11'd5, 17'd0);
    send_item(FUNC_QUERY, 11'd1, 11'd1025, 17'd0);
    send_item(FUNC_QUERY, 11'h7FF, 11'h7FF, 17'h1FFFF);
    send_item(FUNC_QUERY, 11'd3, 11'd3, 17'd0);
    send_item(FUNC_QUERY, 11'd1024, 11'd1024, 17'd0);
    set_leaf_count(11'd0);
    send_item(FUNC_LOAD, 11'd1, 11'd0, 17'd7);
    send_item(FUNC_QUERY, 11'd1, 11'd1, 17'd0);
    set_leaf_count(11'h7FF);
    send_item(FUNC_QUERY, 11'd1, 11'd1024, 17'd0);
    send_item(FUNC_QUERY, 11'd1, 11'd1025, 17'd0);
    // random phases with changing leaf count and idling
    send_idle_pct = 28;
    recv_idle_pct = 62;
    set_leaf_count(11'd1);
    random_burst(40);
    set_leaf_count(11'd37);
    random_burst(140);
    send_idle_pct = 62;
    recv_idle_pct = 28;
    set_leaf_count(11'd1024);
    random_burst(140);
    set_leaf_count(11'd2);
    random_burst(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_leaf_count(11'd700);
    random_burst(190);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
